// ===== rtl/core/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants for the tape wave level slicer
// Item and result layouts, function and register codes, slicing thresholds.
// ----------------------------------------------------------------------------
package tws_pkg;

    // Default prescaler width
    localparam int COUNT_WIDTH_DEF = 16;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int DIVISOR_W  = 16;
    localparam int CFG_DATA_W = 16;

    // Divisor used while no tape is playing, and reset divisor
    localparam logic [DIVISOR_W-1:0] IDLE_DIVISOR  = 16'd20;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd20;

    // Hysteresis thresholds
    localparam logic signed [SAMPLE_W-1:0] WIDE_HIGH   = 16'sh2000;
    localparam logic signed [SAMPLE_W-1:0] WIDE_LOW    = 16'shE000;
    localparam logic [7:0]                 NARROW_HIGH = 8'hA0;
    localparam logic [7:0]                 NARROW_LOW  = 8'h60;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_REWIND = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_EJECT  = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_TICK_DIVISOR   = 1'b0,
        CFG_SAMPLE_IS_WIDE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_func                func;
        logic                 motor_on;
        logic                 sample_valid;
        logic [SAMPLE_W-1:0]  sample_bits;
    } t_item;

    typedef struct packed {
        logic tape_level;
        logic sample_taken;
        logic tape_active;
        logic tape_ended;
    } t_result;

    typedef struct packed {
        logic                  we;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Handshake between the input register and the slicing stage
    typedef struct packed {
        logic  vld;
        t_item item;
    } t_stage;

    // Hysteresis slice: new level from one sample and the held level
    function automatic logic slice_level(input logic                wide,
                                         input logic [SAMPLE_W-1:0] bits,
                                         input logic                level);
        logic res;
        res = level;
        if (wide) begin
            if ($signed(bits) > WIDE_HIGH) begin
                res = 1'b1;
            end else if ($signed(bits) < WIDE_LOW) begin
                res = 1'b0;
            end
        end else begin
            if (bits[7:0] > NARROW_HIGH) begin
                res = 1'b1;
            end else if (bits[7:0] < NARROW_LOW) begin
                res = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/tws_if.sv =====
// ----------------------------------------------------------------------------
// tws_if: channel interfaces for the tape wave level slicer
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tws_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        motor_on;
    logic        sample_valid;
    logic [15:0] sample_bits;

    modport source (output valid, func, motor_on, sample_valid, sample_bits,
                    input ready);
    modport sink   (input valid, func, motor_on, sample_valid, sample_bits,
                    output ready);
endinterface

interface tws_result_if;
    logic valid;
    logic ready;
    logic tape_level;
    logic sample_taken;
    logic tape_active;
    logic tape_ended;

    modport source (output valid, tape_level, sample_taken, tape_active,
                    tape_ended, input ready);
    modport sink   (input valid, tape_level, sample_taken, tape_active,
                    tape_ended, output ready);
endinterface

// ===== rtl/core/tws_in_reg.sv =====
// ----------------------------------------------------------------------------
// tws_in_reg: input register of the tape wave level slicer
// Captures one item per transfer and holds it until the slicing stage takes it.
// ----------------------------------------------------------------------------
module tws_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tws_item_if.sink        i_item,
    input  logic            i_take,
    output tws_pkg::t_stage o_stage
);

    logic           r_vld;
    tws_pkg::t_item r_item;

    // Room when empty or when the held item moves on this cycle
    assign i_item.ready = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.func         <= tws_pkg::t_func'(i_item.func);
            r_item.motor_on     <= i_item.motor_on;
            r_item.sample_valid <= i_item.sample_valid;
            r_item.sample_bits  <= i_item.sample_bits;
        end
    end

    assign o_stage.vld  = r_vld;
    assign o_stage.item = r_item;

endmodule

// ===== rtl/core/tws_core.sv =====
// ----------------------------------------------------------------------------
// tws_core: prescaler, hysteresis slicer and result register
// Updates tape state for one item per cycle unless stalled; registers results.
// ----------------------------------------------------------------------------
module tws_core #(
    parameter int COUNT_WIDTH = tws_pkg::COUNT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tws_pkg::t_cfg_wr i_cfg,
    input  tws_pkg::t_stage i_stage,
    output logic            o_take,
    tws_result_if.source    o_result
);

    localparam int CMP_W = (COUNT_WIDTH > tws_pkg::DIVISOR_W) ?
                           COUNT_WIDTH : tws_pkg::DIVISOR_W;

    // Configuration
    logic [tws_pkg::DIVISOR_W-1:0] r_div;
    logic                          r_wide;

    // Tape state
    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                   r_level, n_level;
    logic                   r_active, n_active;

    // Result register
    logic             r_out_vld;
    tws_pkg::t_result r_res, n_res;

    logic [COUNT_WIDTH-1:0]        cnt_inc;
    logic [tws_pkg::DIVISOR_W-1:0] divisor;
    logic                          fire;
    logic                          load;

    // Stage moves when the result register is free or being drained
    assign o_take = i_stage.vld && (!r_out_vld || o_result.ready);
    assign load   = o_take;

    // Prescaler compare
    assign cnt_inc = r_cnt + COUNT_WIDTH'(1);
    assign divisor = r_active ? r_div : tws_pkg::IDLE_DIVISOR;
    assign fire    = CMP_W'(cnt_inc) >= CMP_W'(divisor);

    // Next state and result for the item in the input register
    always_comb begin
        n_cnt    = r_cnt;
        n_level  = r_level;
        n_active = r_active;
        n_res.sample_taken = 1'b0;
        n_res.tape_ended   = 1'b0;
        case (i_stage.item.func)
            tws_pkg::FUNC_TICK: begin
                n_cnt = fire ? '0 : cnt_inc;
                if (fire && r_active && i_stage.item.motor_on) begin
                    if (i_stage.item.sample_valid) begin
                        n_level = tws_pkg::slice_level(r_wide,
                                                       i_stage.item.sample_bits,
                                                       r_level);
                        n_res.sample_taken = 1'b1;
                    end else begin
                        n_active         = 1'b0;
                        n_res.tape_ended = 1'b1;
                    end
                end
            end
            tws_pkg::FUNC_REWIND: begin
                if (r_active) begin
                    n_level = 1'b0;
                end
            end
            tws_pkg::FUNC_START: n_active = 1'b1;
            tws_pkg::FUNC_EJECT: n_active = 1'b0;
            default: ;
        endcase
        n_res.tape_level  = n_level;
        n_res.tape_active = n_active;
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div     <= tws_pkg::DIVISOR_RESET;
            r_wide    <= 1'b0;
            r_cnt     <= '0;
            r_level   <= 1'b0;
            r_active  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    tws_pkg::CFG_TICK_DIVISOR:   r_div  <= i_cfg.data;
                    tws_pkg::CFG_SAMPLE_IS_WIDE: r_wide <= i_cfg.data[0];
                    default: ;
                endcase
            end
            if (load) begin
                r_cnt    <= n_cnt;
                r_level  <= n_level;
                r_active <= n_active;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid        = r_out_vld;
    assign o_result.tape_level   = r_res.tape_level;
    assign o_result.sample_taken = r_res.sample_taken;
    assign o_result.tape_active  = r_res.tape_active;
    assign o_result.tape_ended   = r_res.tape_ended;

    // Checks
    a_taken_ended_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_res.sample_taken && r_res.tape_ended))
        else $error("sample taken and tape ended in one result");

    a_result_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_res.tape_active == r_active && r_res.tape_level == r_level))
        else $error("result out of step with tape state");

    a_end_stops_tape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_res.tape_ended) |=> !r_active)
        else $error("tape still active after end");

    a_fire_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_stage.item.func == tws_pkg::FUNC_TICK && fire) |=> (r_cnt == '0))
        else $error("prescaler not cleared on fire");

endmodule

// ===== rtl/core/tape_wave_level_slicer_top.sv =====
// ----------------------------------------------------------------------------
// tape_wave_level_slicer_top: cassette level from recorded audio samples
// Prescaled hysteresis slicer with tape start, eject, rewind and end handling.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the result side stalls, and returns exactly
// one result for it. An item is held in the input register, then the prescaler
// compare and the slicer update the tape state and load the result register,
// which holds the result until it transfers. Throughput is one item per cycle
// as long as the result side takes results, because the prescaler count, the
// level and the active flag are all updated in the same cycle that loads the
// result. The configuration port writes tick_divisor (index 0) and
// sample_is_wide (index 1); write it only while no item is in flight.
module tape_wave_level_slicer_top #(
    parameter int COUNT_WIDTH = tws_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [tws_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tws_item_if.sink                       i_item,
    tws_result_if.source                   o_result
);

    tws_pkg::t_cfg_wr cfg;
    tws_pkg::t_stage  stage;
    logic             take;

    // Configuration write bundle
    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = tws_pkg::t_cfg_idx'(i_cfg_idx);
    assign cfg.data = i_cfg_data;

    tws_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (take),
        .o_stage (stage)
    );

    tws_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_stage  (stage),
        .o_take   (take),
        .o_result (o_result)
    );

endmodule
